[sv/settled_level_matcher_macros.svh]
// Assertion macros for the level matcher
`ifndef SETTLED_LEVEL_MATCHER_MACROS_SVH
`define SETTLED_LEVEL_MATCHER_MACROS_SVH
`ifndef ASSERT_OFF
// checked only out of reset
`define SLM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge
`define SLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLM_ASSERT(lbl, clk, rst, prop, msg)
`define SLM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/slm_pkg.sv]
package slm_pkg;

  localparam int NUM_LEVELS = 15;
  localparam int SAMPLE_BITS = 12;
  localparam int SLOT_W = 4;
  localparam int MEAN_SHIFT = 4;
  localparam logic [SLOT_W-1:0] COMBO_NONE = 4'd15;
  localparam int LEVEL_SPAN = (1 << SAMPLE_BITS) - 1;
  localparam int LEVEL_LO = -(1 << (SAMPLE_BITS - 1));

  // function codes
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;
  localparam logic [1:0] FUNC_SPARE   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SMOOTH_SHIFT = 3'd0;
  localparam logic [2:0] REG_SETTLE_TOL   = 3'd1;
  localparam logic [2:0] REG_SETTLE_TICKS = 3'd2;
  localparam logic [2:0] REG_DEADBAND     = 3'd3;
  localparam logic [2:0] REG_MATCH_WINDOW = 3'd4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // one learned level: its index and centre value
  typedef struct packed {
    logic [SLOT_W-1:0] idx;
    sample_t           val;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic              load;
    logic [SLOT_W-1:0] wr_idx;
    sample_t           wr_val;
    logic              swap_r_en;
    logic              swap_l_en;
  } cell_ctl_t;

  // even spread over the sample range, used at reset
  function automatic sample_t reset_level(int i);
    int v;
    v = LEVEL_LO + (LEVEL_SPAN * i) / (NUM_LEVELS - 1);
    return SAMPLE_BITS'(v);
  endfunction

  // sort key: value first, index breaks ties (keeps a stable order)
  function automatic logic entry_gt(entry_t a, entry_t b);
    return (a.val > b.val) || ((a.val == b.val) && (a.idx > b.idx));
  endfunction

  // one-pole slew, at least one unit toward the target
  function automatic sample_t slew(sample_t cur, sample_t tgt, logic [3:0] sh);
    logic signed [SAMPLE_BITS:0] d;
    logic [SAMPLE_BITS:0] mag;
    logic [SAMPLE_BITS:0] step;
    logic signed [SAMPLE_BITS:0] res;
    d = {tgt[SAMPLE_BITS-1], tgt} - {cur[SAMPLE_BITS-1], cur};
    mag = d[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d) : d;
    step = mag >> sh;
    if (step == '0 && mag != '0) begin
      step = (SAMPLE_BITS+1)'(1);
    end
    res = d[SAMPLE_BITS] ? ({cur[SAMPLE_BITS-1], cur} - $signed(step))
                         : ({cur[SAMPLE_BITS-1], cur} + $signed(step));
    return res[SAMPLE_BITS-1:0];
  endfunction

endpackage

[sv/slm_cell.sv]
module slm_cell (
  input  logic              clk,
  input  logic              rst,
  input  slm_pkg::cell_ctl_t ctl,
  input  slm_pkg::entry_t   rst_ent,
  input  slm_pkg::entry_t   left,
  input  slm_pkg::entry_t   right,
  input  slm_pkg::sample_t  match_val,
  output slm_pkg::entry_t   ent,
  output logic signed [slm_pkg::SAMPLE_BITS-1:0] thr,
  output logic              above_thr
);
  import slm_pkg::*;

  logic signed [SAMPLE_BITS:0] pair_sum;

  // midpoint toward the right neighbor, floor division
  assign pair_sum = {ent.val[SAMPLE_BITS-1], ent.val} + {right.val[SAMPLE_BITS-1], right.val};
  assign thr = pair_sum[SAMPLE_BITS:1];
  assign above_thr = match_val > thr;

  // level replace, then odd-even exchange with a neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= rst_ent;
    end else if (ctl.load && ent.idx == ctl.wr_idx) begin
      ent.val <= ctl.wr_val;
    end else if (ctl.swap_r_en && entry_gt(ent, right)) begin
      ent <= right;
    end else if (ctl.swap_l_en && entry_gt(left, ent)) begin
      ent <= left;
    end
  end

endmodule

[sv/settled_level_matcher.sv]
// Channel | Handshake                 | Payload
// in      | in_valid / in_ready       | func, cv_sample, level_index, level_value
// out     | out_valid / out_ready     | trigger, note_index, held_combo
// cfg     | cfg_we (no wait)          | cfg_addr, cfg_wdata
// A sample tick steps through slew, settle and result, with three match stages
// added between settle and result when the plateau is matched.
// A level write steps through load, 15 odd-even passes over the cell row, and result;
// an out-of-range index, release and unknown codes go from decode to the result. One item in work.
// rst is synchronous; the cell row comes out of reset already sorted.
// A stalled output holds the result; the next item may be taken meanwhile.
module settled_level_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic signed [slm_pkg::SAMPLE_BITS-1:0] cv_sample,
  input  logic [3:0]  level_index,
  input  logic signed [slm_pkg::SAMPLE_BITS-1:0] level_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        trigger,
  output logic [3:0]  note_index,
  output logic [3:0]  held_combo,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);
  import slm_pkg::*;
  `include "settled_level_matcher_macros.svh"

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SMOOTH  = 8'b0000_0010,
    S_SETTLE  = 8'b0000_0100,
    S_MATCH_A = 8'b0000_1000,
    S_MATCH_B = 8'b0001_0000,
    S_MATCH_C = 8'b0010_0000,
    S_SORT    = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration
  logic [3:0] smooth_shift;
  logic [7:0] settle_tolerance, settle_ticks, deadband;
  logic [9:0] match_window;

  // captured transaction
  logic [1:0] func_r;
  sample_t sample_r;
  logic [SLOT_W-1:0] lidx_r;
  sample_t lval_r;

  // tracking state
  sample_t smoothed, mean;
  logic [7:0] ticks;
  logic [SLOT_W-1:0] held;
  logic primed;

  // match pipeline
  logic [SLOT_W-1:0] k_r, cs_r, cand_r;
  logic cs_hit;
  logic [SLOT_W-1:0] sort_cnt;
  logic res_trig;
  logic [SLOT_W-1:0] res_note;

  entry_t ents [NUM_LEVELS];
  logic signed [SAMPLE_BITS-1:0] thrs [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] above;
  logic sort_act, phase, load_act;

  assign in_ready = (state == S_IDLE);
  assign sort_act = (state == S_SORT);
  assign phase = sort_cnt[0];
  assign load_act = (state == S_SMOOTH) && (func_r == FUNC_WRITE);

  // cell row
  for (genvar k = 0; k < NUM_LEVELS; k++) begin : g_cell
    cell_ctl_t ctl;
    entry_t rst_ent, left_e, right_e;
    assign rst_ent.idx = SLOT_W'(k);
    assign rst_ent.val = reset_level(k);
    assign ctl.load = load_act;
    assign ctl.wr_idx = lidx_r;
    assign ctl.wr_val = lval_r;
    assign ctl.swap_r_en = sort_act && (1'(k % 2) == phase) && (k < NUM_LEVELS - 1);
    assign ctl.swap_l_en = sort_act && (1'((k + 1) % 2) == phase) && (k > 0);
    if (k > 0) begin : g_l
      assign left_e = ents[k-1];
    end else begin : g_l0
      assign left_e = ents[k];
    end
    if (k < NUM_LEVELS - 1) begin : g_r
      assign right_e = ents[k+1];
    end else begin : g_rn
      assign right_e = ents[k];
    end
    slm_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .rst_ent(rst_ent),
      .left(left_e), .right(right_e), .match_val(mean),
      .ent(ents[k]), .thr(thrs[k]), .above_thr(above[k])
    );
  end

  // first slot not above its threshold, and the held level's slot
  logic [SLOT_W-1:0] k_find, cs_find;
  logic cs_found;
  always_comb begin
    k_find = SLOT_W'(NUM_LEVELS - 1);
    for (int i = NUM_LEVELS - 2; i >= 0; i--) begin
      if (!above[i]) begin
        k_find = SLOT_W'(i);
      end
    end
    cs_find = '0;
    cs_found = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (ents[i].idx == held) begin
        cs_find = SLOT_W'(i);
        cs_found = 1'b1;
      end
    end
  end

  // deadband toward an adjacent held level
  logic [SLOT_W-1:0] km1, cand_sel;
  logic signed [SAMPLE_BITS+1:0] up_lim, dn_lim, mean_x;
  always_comb begin
    km1 = (k_r == '0) ? '0 : k_r - 1'b1;
    mean_x = (SAMPLE_BITS+2)'(mean);
    up_lim = (SAMPLE_BITS+2)'(thrs[k_r]) - $signed({6'b0, deadband});
    dn_lim = (SAMPLE_BITS+2)'(thrs[km1]) + $signed({6'b0, deadband});
    cand_sel = k_r;
    if (cs_hit && ents[k_r].idx != held) begin
      if (cs_r == k_r + 1'b1 && mean_x > up_lim) begin
        cand_sel = cs_r;
      end else if (cs_r == km1 && k_r != '0 && mean_x < dn_lim) begin
        cand_sel = cs_r;
      end
    end
  end

  // window check and held-combo update
  logic signed [SAMPLE_BITS:0] mean_gap;
  logic [SAMPLE_BITS:0] adist;
  logic [SLOT_W-1:0] m;
  assign mean_gap = {mean[SAMPLE_BITS-1], mean}
                  - {ents[cand_r].val[SAMPLE_BITS-1], ents[cand_r].val};
  assign adist = mean_gap[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-mean_gap) : mean_gap;
  assign m = (adist > (SAMPLE_BITS+1)'(match_window)) ? COMBO_NONE : ents[cand_r].idx;

  // settle detection on the new smoothed value
  logic signed [SAMPLE_BITS:0] sdiff;
  logic [SAMPLE_BITS:0] sabs;
  assign sdiff = {smoothed[SAMPLE_BITS-1], smoothed} - {mean[SAMPLE_BITS-1], mean};
  assign sabs = sdiff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-sdiff) : sdiff;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_shift <= 4'd3;
      settle_tolerance <= 8'd8;
      settle_ticks <= 8'd36;
      deadband <= 8'd16;
      match_window <= 10'd64;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SMOOTH_SHIFT: smooth_shift <= cfg_wdata[3:0];
        REG_SETTLE_TOL:   settle_tolerance <= cfg_wdata[7:0];
        REG_SETTLE_TICKS: settle_ticks <= cfg_wdata[7:0];
        REG_DEADBAND:     deadband <= cfg_wdata[7:0];
        REG_MATCH_WINDOW: match_window <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      smoothed <= '0;
      mean <= '0;
      ticks <= '0;
      held <= COMBO_NONE;
      primed <= 1'b0;
      out_valid <= 1'b0;
      sort_cnt <= '0;
      res_trig <= 1'b0;
      res_note <= '0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= func;
            sample_r <= cv_sample;
            lidx_r <= level_index;
            lval_r <= level_value;
            res_trig <= 1'b0;
            res_note <= '0;
            state <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          sort_cnt <= '0;
          case (func_r)
            FUNC_TICK: begin
              smoothed <= slew(smoothed, sample_r, smooth_shift);
              state <= S_SETTLE;
            end
            FUNC_WRITE: begin
              state <= (lidx_r < SLOT_W'(NUM_LEVELS)) ? S_SORT : S_DONE;
            end
            FUNC_RELEASE: begin
              held <= COMBO_NONE;
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_SETTLE: begin
          if (ticks != '0 && sabs <= (SAMPLE_BITS+1)'(settle_tolerance)) begin
            mean <= slew(mean, smoothed, 4'(MEAN_SHIFT));
            if (ticks < settle_ticks) begin
              ticks <= ticks + 1'b1;
              state <= (ticks + 1'b1 < settle_ticks) ? S_DONE : S_MATCH_A;
            end else begin
              state <= S_MATCH_A;
            end
          end else begin
            mean <= smoothed;
            ticks <= 8'd1;
            state <= S_DONE;
          end
        end
        S_MATCH_A: begin
          k_r <= k_find;
          cs_r <= cs_find;
          cs_hit <= cs_found;
          state <= S_MATCH_B;
        end
        S_MATCH_B: begin
          cand_r <= cand_sel;
          state <= S_MATCH_C;
        end
        S_MATCH_C: begin
          if (m != COMBO_NONE && m != held) begin
            held <= m;
            if (primed) begin
              res_trig <= 1'b1;
              res_note <= m;
            end
            primed <= 1'b1;
          end
          state <= S_DONE;
        end
        S_SORT: begin
          sort_cnt <= sort_cnt + 1'b1;
          if (sort_cnt == SLOT_W'(NUM_LEVELS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            trigger <= res_trig;
            note_index <= res_note;
            held_combo <= held;
            state <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SLM_ASSERT(a_note_is_held, clk, rst, out_valid && trigger |-> note_index == held_combo, "note differs from held combo")
  `SLM_ASSERT(a_trig_held, clk, rst, out_valid && trigger |-> held_combo != COMBO_NONE, "trigger with nothing held")
  `SLM_ASSERT(a_accept_busy, clk, rst, in_valid && in_ready |=> !in_ready, "accepted without going busy")

endmodule

[bench/level_match_checker.sv]
`timescale 1ns / 100ps

module level_match_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             func,
  input  logic signed [slm_pkg::SAMPLE_BITS-1:0] cv_sample,
  input  logic [3:0]             level_index,
  input  logic signed [slm_pkg::SAMPLE_BITS-1:0] level_value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   trigger,
  input  logic [3:0]             note_index,
  input  logic [3:0]             held_combo,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_addr,
  input  logic [9:0]             cfg_wdata,
  output int                     fail_count,
  output int                     pending_count
);
  import slm_pkg::*;

  typedef struct packed {
    logic       trig;
    logic [3:0] note;
    logic [3:0] held;
  } note_result_t;

  note_result_t expected_notes[$];

  // predictor copy of the registers
  int shift_r, tol_r, ticks_r, db_r, win_r;
  // predictor copy of the state
  int smooth_v, mean_v, plat_ticks, held_v;
  bit primed;
  int levels[NUM_LEVELS];
  int order[NUM_LEVELS];
  int thresh[NUM_LEVELS];
  int slot_of[NUM_LEVELS];

  function automatic int abs_i(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int step_toward(int cur, int tgt, int sh);
    int d, mag, st;
    d = tgt - cur;
    mag = abs_i(d);
    st = mag >> sh;
    if (st == 0 && mag != 0) st = 1;
    return d < 0 ? cur - st : cur + st;
  endfunction

  function automatic int floor_half(int v);
    return v >= 0 ? v >>> 1 : -(((-v) - 1) >>> 1) - 1;
  endfunction

  // stable insertion sort plus midpoint thresholds
  task automatic resort_levels();
    int j, key;
    for (int i = 0; i < NUM_LEVELS; i++) order[i] = i;
    for (int i = 1; i < NUM_LEVELS; i++) begin
      key = order[i];
      j = i - 1;
      while (j >= 0 && levels[order[j]] > levels[key]) begin
        order[j+1] = order[j];
        j--;
      end
      order[j+1] = key;
    end
    for (int k = 0; k < NUM_LEVELS - 1; k++)
      thresh[k] = floor_half(levels[order[k]] + levels[order[k+1]]);
    for (int k = 0; k < NUM_LEVELS; k++) slot_of[order[k]] = k;
  endtask

  function automatic int nearest_level(int v, int cur);
    int k, cand, cs;
    k = 0;
    while (k < NUM_LEVELS - 1 && v > thresh[k]) k++;
    cand = order[k];
    if (cur < NUM_LEVELS && cand != cur) begin
      cs = slot_of[cur];
      if (cs == k + 1 && v > thresh[k] - db_r) cand = cur;
      else if (cs == k - 1 && k >= 1 && v < thresh[k-1] + db_r) cand = cur;
    end
    if (abs_i(v - levels[cand]) > win_r) return COMBO_NONE;
    return cand;
  endfunction

  task automatic sample_tick(int s, output logic trig, output logic [3:0] note);
    int m;
    trig = 0;
    note = '0;
    smooth_v = step_toward(smooth_v, s, shift_r);
    if (plat_ticks > 0 && abs_i(smooth_v - mean_v) <= tol_r) begin
      mean_v = step_toward(mean_v, smooth_v, MEAN_SHIFT);
      if (plat_ticks < ticks_r) plat_ticks++;
    end else begin
      mean_v = smooth_v;
      plat_ticks = 1;
      return;
    end
    if (plat_ticks < ticks_r) return;
    m = nearest_level(mean_v, held_v);
    if (m == COMBO_NONE || m == held_v) return;
    held_v = m;
    if (!primed) begin
      primed = 1;
      return;
    end
    trig = 1;
    note = 4'(m);
  endtask

  assign pending_count = expected_notes.size();

  always @(posedge clk) begin
    note_result_t exp_r, got;
    if (rst) begin
      shift_r = 3; tol_r = 8; ticks_r = 36; db_r = 16; win_r = 64;
      smooth_v = 0; mean_v = 0; plat_ticks = 0; held_v = COMBO_NONE; primed = 0;
      for (int i = 0; i < NUM_LEVELS; i++)
        levels[i] = LEVEL_LO + (LEVEL_SPAN * i) / (NUM_LEVELS - 1);
      resort_levels();
      expected_notes.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SMOOTH_SHIFT: shift_r = cfg_wdata[3:0];
          REG_SETTLE_TOL:   tol_r = cfg_wdata[7:0];
          REG_SETTLE_TICKS: ticks_r = cfg_wdata[7:0];
          REG_DEADBAND:     db_r = cfg_wdata[7:0];
          REG_MATCH_WINDOW: win_r = cfg_wdata;
          default: ;
        endcase
      end
      // predict the result of an accepted input transaction
      if (in_valid && in_ready) begin
        exp_r = '0;
        case (func)
          FUNC_TICK: sample_tick(int'(cv_sample), exp_r.trig, exp_r.note);
          FUNC_WRITE: begin
            if (level_index < NUM_LEVELS) begin
              levels[level_index] = int'(level_value);
              resort_levels();
            end
          end
          FUNC_RELEASE: held_v = COMBO_NONE;
          default: ;
        endcase
        exp_r.held = 4'(held_v);
        expected_notes.push_back(exp_r);
      end
      // compare an accepted output transaction
      if (out_valid && out_ready) begin
        got = '{trigger, note_index, held_combo};
        if (expected_notes.size() == 0) begin
          $error("unexpected result trigger=%0d note=%0d held=%0d",
                 trigger, note_index, held_combo);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_notes.pop_front();
          if (got != exp_r) begin
            if (got.trig != exp_r.trig)
              $error("trigger expected %0d got %0d", exp_r.trig, got.trig);
            if (got.note != exp_r.note)
              $error("note_index expected %0d got %0d", exp_r.note, got.note);
            if (got.held != exp_r.held)
              $error("held_combo expected %0d got %0d", exp_r.held, got.held);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import slm_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic [1:0] func = FUNC_TICK;
  logic signed [SAMPLE_BITS-1:0] cv_sample = '0, level_value = '0;
  logic [3:0] level_index = '0;
  logic out_valid, out_ready = 0;
  logic trigger;
  logic [3:0] note_index, held_combo;
  logic cfg_we = 0;
  logic [2:0] cfg_addr = REG_SMOOTH_SHIFT;
  logic [9:0] cfg_wdata = '0;
  int fail_count, pending_count;
  int idle_cycles = 0;
  bit stall_burst = 0;

  settled_level_matcher DUT (.*);

  level_match_checker checker_i (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver backpressure: mostly short stalls, sometimes long
  always @(posedge clk) begin
    if ($urandom_range(0, 99) < 3) stall_burst <= ~stall_burst;
    if (stall_burst) out_ready <= ($urandom_range(0, 9) < 8);
    else if ($urandom_range(0, 49) == 0) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid drops only ahead of a gap; back-to-back items keep it high
  task automatic send_item(logic [1:0] f, int s, int idx, int lv);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    cv_sample <= s;
    level_index <= idx;
    level_value <= lv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [2:0] a, int v);
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic hold_level(int v, int n);
    repeat (n) send_item(FUNC_TICK, v + $urandom_range(0, 4) - 2, 0, 0);
  endtask

  // n random items, mostly plateaus near the reset level spread
  task automatic random_phase(int n);
    int r, tgt;
    tgt = 0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_item(FUNC_WRITE, 0, $urandom_range(0, 15), $urandom);
      else if (r < 7) send_item(FUNC_RELEASE, $urandom, $urandom, $urandom);
      else if (r < 8) send_item(FUNC_SPARE, $urandom, $urandom, $urandom);
      else if (r < 14) send_item(FUNC_TICK, $urandom, $urandom, $urandom);
      else begin
        if ($urandom_range(0, 39) == 0)
          tgt = LEVEL_LO + (LEVEL_SPAN * $urandom_range(0, 14)) / 14
                + $urandom_range(0, 100) - 50;
        if (tgt > 2047) tgt = 2047;
        if (tgt < -2048) tgt = -2048;
        send_item(FUNC_TICK, tgt + $urandom_range(0, 6) - 3, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: first settle swallowed, then a trigger, release, writes, extremes
    hold_level(0, 40);
    hold_level(-1170, 60);
    send_item(FUNC_RELEASE, 0, 0, 0);
    send_item(FUNC_SPARE, -2048, 15, 2047);
    send_item(FUNC_WRITE, 0, 15, 100);
    send_item(FUNC_WRITE, 0, 3, 2047);
    send_item(FUNC_WRITE, 0, 14, -2048);
    send_item(FUNC_WRITE, 0, 5, 2047);
    send_item(FUNC_TICK, 2047, 0, 0);
    send_item(FUNC_TICK, -2048, 0, 0);
    drain();

    // extremes of every register
    write_reg(REG_SMOOTH_SHIFT, 0);
    write_reg(REG_SETTLE_TOL, 255);
    write_reg(REG_SETTLE_TICKS, 0);
    write_reg(REG_DEADBAND, 255);
    write_reg(REG_MATCH_WINDOW, 1023);
    random_phase(200);
    drain();

    write_reg(REG_SMOOTH_SHIFT, 15);
    write_reg(REG_SETTLE_TOL, 0);
    write_reg(REG_SETTLE_TICKS, 255);
    write_reg(REG_DEADBAND, 0);
    write_reg(REG_MATCH_WINDOW, 0);
    random_phase(100);
    drain();

    write_reg(REG_SMOOTH_SHIFT, 2);
    write_reg(REG_SETTLE_TOL, 12);
    write_reg(REG_SETTLE_TICKS, 4);
    write_reg(REG_DEADBAND, 40);
    write_reg(REG_MATCH_WINDOW, 200);
    random_phase(200);
    drain();

    write_reg(REG_SMOOTH_SHIFT, 8);
    write_reg(REG_SETTLE_TOL, 30);
    write_reg(REG_SETTLE_TICKS, 1);
    write_reg(REG_DEADBAND, 128);
    write_reg(REG_MATCH_WINDOW, 512);
    random_phase(250);
    drain();

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
